>>> rtl/core/pesc_pkg.sv
// Package for the photon energy scale correction pipeline.
// Holds fixed-point formats, polynomial coefficients and the rounding multiply.
// No dependencies.
`default_nettype none
package pesc_pkg;

    // default parameter values
    localparam int ENERGY_BITS_DEF     = 24;
    localparam int RATIO_FRAC_BITS_DEF = 15;

    // Horner accumulator, r9 in Q.20 and divisor widths
    localparam int TW = 40;
    localparam int XW = 23;
    localparam int DW = 36;
    localparam int QF = 20;
    localparam int QW = 20;

    localparam logic signed [TW-1:0] QONE      = TW'(64'sd1 << QF);
    localparam logic [XW-1:0]        XCAP_Q20  = XW'(4 << QF);
    localparam logic [DW-1:0]        DIV5X5_Q20 = DW'(1017935);
    localparam longint               STEP_Q20  = 933233;

    // per region: A0, A1, A2, B0, B1, B2 in Q.20
    localparam longint COEF [2][6] = '{
        '{-64'sd68844, 64'sd44255, -64'sd11525,
          -64'sd132248502, 64'sd151261282, -64'sd57437428},
        '{-64'sd44464, -64'sd30843, 64'sd65769,
          -64'sd100823309, 64'sd116564951, -64'sd44683913}
    };

    // elaboration-time product, rounded half away from zero
    function automatic longint mul_q20_c(input longint a, input longint b);
        longint ua;
        longint ub;
        longint p;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p  = (ua * ub + (64'sd1 <<< 19)) >>> 20;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic longint horner3_c(input longint c0, input longint c1,
                                         input longint c2, input longint c3,
                                         input longint x);
        longint t;
        t = c3;
        t = c2 + mul_q20_c(t, x);
        t = c1 + mul_q20_c(t, x);
        return c0 + mul_q20_c(t, x);
    endfunction

    // offset that joins the cubic to the quadratic at the step
    function automatic longint calc_offset(input int r);
        return horner3_c(COEF[r][0], COEF[r][1], COEF[r][2], 0, STEP_Q20)
             - horner3_c(0, COEF[r][3], COEF[r][4], COEF[r][5], STEP_Q20);
    endfunction

    localparam longint OFFSET [2] = '{calc_offset(0), calc_offset(1)};

    // Horner coefficient k0..k3 for the region and the side of the step
    function automatic logic signed [TW-1:0] coef_k(input logic region,
                                                    input logic upper,
                                                    input int   idx);
        logic signed [TW-1:0] k;
        case (idx)
            0:       k = upper ? TW'(OFFSET[region]) : TW'(COEF[region][0]);
            1:       k = upper ? TW'(COEF[region][3]) : TW'(COEF[region][1]);
            2:       k = upper ? TW'(COEF[region][4]) : TW'(COEF[region][2]);
            3:       k = upper ? TW'(COEF[region][5]) : '0;
            default: k = '0;
        endcase
        return k;
    endfunction

    // Q.20 product of a signed term and nonnegative r9, half away from zero
    function automatic logic signed [TW-1:0] mul_q20(input logic signed [TW-1:0] a,
                                                     input logic [XW-1:0] b);
        logic [TW-1:0]    ua;
        logic [TW+XW-1:0] p;
        logic [TW-1:0]    m;
        ua = a[TW-1] ? (~a + 1'b1) : a;
        p  = (TW+XW)'(ua) * (TW+XW)'(b) + (TW+XW)'(1 << (QF - 1));
        m  = p[TW+QF-1:QF];
        return a[TW-1] ? $signed(~m + 1'b1) : $signed(m);
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/photon_energy_scale_correction_top.sv
// Top level of the photon energy scale correction pipeline.
// Depends on pesc_pkg and pesc_divider.
//
//  channel   dir  tdata (low bit up)                          tuser
//  s_axis    in   shape_ratio, supercluster, 5x5, photon E     region
//  m_axis    out  scale_factor (zero padded to 24 bits)        divide_error
//
// One transaction per cycle while m_axis is ready; 5 polynomial and divisor
// stages, then 21 divider stages: an overflow test, then a quotient bit each.
// Reset clears only the valid bits of the stages.
// A stall backs up stage by stage; empty stages keep filling while the output
// waits, so nothing is lost or repeated.
`default_nettype none
module photon_energy_scale_correction_top
    import pesc_pkg::*;
#(
    parameter int ENERGY_BITS     = ENERGY_BITS_DEF,
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_axis_tvalid,
    output logic      o_s_axis_tready,
    // shape_ratio, supercluster_energy, cluster_5x5_energy, photon_energy
    input  wire logic [((16 + 3 * ENERGY_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // region
    input  wire logic i_s_axis_tuser,
    output logic      o_m_axis_tvalid,
    input  wire logic i_m_axis_tready,
    // scale_factor
    output logic [23:0] o_m_axis_tdata,
    // divide_error
    output logic        o_m_axis_tuser
);
    localparam int EB = ENERGY_BITS;
    localparam int F  = RATIO_FRAC_BITS;
    localparam logic [20:0] RAW_ONE  = 21'(1 << F);
    localparam logic [20:0] RAW_STEP = 21'((89 * (2 ** F)) / 100);
    localparam logic [20:0] RAW_CUT5 = 21'((94 * (2 ** F)) / 100);

    // stage valid bits and enables
    logic [5:1] r_v;
    logic [6:1] w_en;
    logic       w_div_ready;

    // carried fields
    logic              r_region [1:4];
    logic              r_upper  [1:4];
    logic              r_use5   [1:4];
    logic [XW-1:0]     r_x      [1:4];
    logic [EB-1:0]     r_esc    [1:4];
    logic [EB-1:0]     r_e5     [1:4];
    logic [EB-1:0]     r_eph    [1:4];
    logic signed [TW-1:0] r_t1, r_t2, r_d;

    // stage 5 outputs
    logic              r_err5;
    logic [EB-1:0]     r_num5;
    logic [DW+EB-1:0]  r_prod5;

    logic [20:0]       n_raw;
    logic [30:0]       n_xf;
    logic [XW-1:0]     n_x;
    logic              n_err5;
    logic [DW-1:0]     n_den5;

    logic [QW-1:0]     w_factor;

    assign w_en[6] = w_div_ready;
    for (genvar k = 1; k <= 5; k++) begin : g_en
        assign w_en[k] = !r_v[k] || w_en[k+1];
    end
    assign o_s_axis_tready = w_en[1];

    // clamp r9 and rescale to Q.20
    always_comb begin
        n_raw = {5'b0, i_s_axis_tdata[15:0]};
        if (!i_s_axis_tuser && n_raw > RAW_ONE) begin
            n_raw = RAW_ONE;
        end
        n_xf = 31'(n_raw) << (QF - F);
        n_x  = (n_xf > 31'(XCAP_Q20)) ? XCAP_Q20 : n_xf[XW-1:0];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) r_v[1] <= i_s_axis_tvalid;
            for (int k = 2; k <= 5; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: classify and capture
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_region[1] <= i_s_axis_tuser;
            r_upper[1]  <= n_raw > RAW_STEP;
            r_use5[1]   <= !i_s_axis_tuser && (n_raw > RAW_CUT5);
            r_x[1]      <= n_x;
            r_esc[1]    <= i_s_axis_tdata[16 +: EB];
            r_e5[1]     <= i_s_axis_tdata[16 + EB +: EB];
            r_eph[1]    <= i_s_axis_tdata[16 + 2 * EB +: EB];
        end
    end

    // stages 2 to 4: carry fields alongside Horner steps
    for (genvar k = 2; k <= 4; k++) begin : g_carry
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_region[k] <= r_region[k-1];
                r_upper[k]  <= r_upper[k-1];
                r_use5[k]   <= r_use5[k-1];
                r_x[k]      <= r_x[k-1];
                r_esc[k]    <= r_esc[k-1];
                r_e5[k]     <= r_e5[k-1];
                r_eph[k]    <= r_eph[k-1];
            end
        end
    end

    // Horner steps, one multiply per stage; stage 4 holds d = 1 + f
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_t1 <= coef_k(r_region[1], r_upper[1], 2)
                  + mul_q20(coef_k(r_region[1], r_upper[1], 3), r_x[1]);
        end
        if (w_en[3]) begin
            r_t2 <= coef_k(r_region[2], r_upper[2], 1) + mul_q20(r_t1, r_x[2]);
        end
        if (w_en[4]) begin
            r_d <= coef_k(r_region[3], r_upper[3], 0) + QONE + mul_q20(r_t2, r_x[3]);
        end
    end

    // stage 5: pick numerator and divisor, form divisor times photon energy
    always_comb begin
        n_err5 = (r_eph[4] == '0) || (!r_use5[4] && (r_d[TW-1] || r_d == '0));
        n_den5 = r_use5[4] ? DIV5X5_Q20 : r_d[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_err5  <= n_err5;
            r_num5  <= r_use5[4] ? r_e5[4] : r_esc[4];
            r_prod5 <= (DW+EB)'(n_den5) * (DW+EB)'(r_eph[4]);
        end
    end

    pesc_divider #(
        .ENERGY_BITS (ENERGY_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v[5]),
        .o_ready  (w_div_ready),
        .i_err    (r_err5),
        .i_num    (r_num5),
        .i_prod   (r_prod5),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_factor (w_factor),
        .o_err    (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {4'b0, w_factor};

endmodule
`default_nettype wire

>>> rtl/core/pesc_divider.sv
// Pipelined restoring divider: floor(num * 2^36 / prod), saturated to 20 bits.
// 21 stages, an overflow test then a quotient bit each. Depends on pesc_pkg.
`default_nettype none
module pesc_divider
    import pesc_pkg::*;
#(
    parameter int ENERGY_BITS = ENERGY_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_err,
    input  wire logic [ENERGY_BITS-1:0]    i_num,
    input  wire logic [DW+ENERGY_BITS-1:0] i_prod,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [QW-1:0]                  o_factor,
    output logic                           o_err
);
    localparam int PW = DW + ENERGY_BITS;
    localparam int RW = PW + 1;
    localparam int NS = QW + 1;

    logic [NS-1:0]   r_v;
    logic [NS:0]     w_en;
    logic            r_err  [NS];
    logic            r_flag [NS];
    logic [RW-1:0]   r_rem  [NS];
    logic [PW-1:0]   r_den  [NS];
    logic [QW-1:0]   r_q    [NS];
    logic [RW-1:0]   n_rem0;
    logic            n_sat;

    // advance a stage when it is empty or the next one advances
    assign w_en[NS] = i_ready;
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign w_en[k] = !r_v[k] || w_en[k+1];
    end
    assign o_ready = w_en[0];

    // first stage: overflow test, remainder starts at num * 2^16
    always_comb begin
        n_rem0 = RW'(i_num) << (36 - QW);
        n_sat  = n_rem0 >= RW'(i_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en[0]) begin
            r_v[0] <= i_valid;
        end
        if (w_en[0]) begin
            r_err[0]  <= i_err;
            r_flag[0] <= i_err || n_sat;
            r_rem[0]  <= n_rem0;
            r_den[0]  <= i_prod;
            r_q[0]    <= '0;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k < NS; k++) begin : g_step
        logic [RW-1:0] w_sh;
        logic          w_ge;
        assign w_sh = r_rem[k-1] << 1;
        assign w_ge = w_sh >= RW'(r_den[k-1]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= r_v[k-1];
            end
            if (w_en[k]) begin
                r_err[k]  <= r_err[k-1];
                r_flag[k] <= r_flag[k-1];
                r_rem[k]  <= w_ge ? (w_sh - RW'(r_den[k-1])) : w_sh;
                r_den[k]  <= r_den[k-1];
                r_q[k]    <= {r_q[k-1][QW-2:0], w_ge};
            end
        end
    end

    // drive the result, all ones on error or overflow
    assign o_valid  = r_v[NS-1];
    assign o_err    = r_err[NS-1];
    assign o_factor = r_flag[NS-1] ? '1 : r_q[NS-1];

endmodule
`default_nettype wire

>>> rtl/core/pesc_checker.sv
// Port-level checks for the photon energy scale correction top level.
// Bound to photon_energy_scale_correction_top; no package needed.
`default_nettype none
module pesc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tuser
);
    // hold a stalled result
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // an error result carries the saturated factor
    a_err_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[19:0] == 20'hFFFFF)
        else $error("error result not saturated");

    // pad bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[23:20] == 4'b0)
        else $error("pad bits set");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result after reset");

endmodule

bind photon_energy_scale_correction_top pesc_checker u_pesc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire
